[rtl/core/lsps_pkg.sv]
// Shared types, constants and helpers for the line sensor PID steering core.
// No dependencies; the interfaces and the core import it.
`timescale 1ns / 1ps

package lsps_pkg;

  localparam int unsigned SensorW   = 5;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned GainW     = 12;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned DriveW    = 24;
  localparam int unsigned SumW      = 16;
  localparam int unsigned ErrW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TableLen  = 11;

  localparam logic [IndexW-1:0] CenterIndex = 4'd5;
  localparam logic [IndexW-1:0] LitIndex    = 4'd0;
  localparam logic [IndexW-1:0] DarkIndex   = 4'd10;

  localparam logic [ModeW-1:0] ModeStopped = 2'd0;
  localparam logic [ModeW-1:0] ModeFollow  = 2'd1;
  localparam logic [ModeW-1:0] ModeCurve   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegGainProp  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGainInteg = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGainDeriv = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBaseSpeed = 2'd3;

  localparam logic [GainW-1:0]  GainPropRst  = 12'd128;
  localparam logic [GainW-1:0]  GainIntegRst = 12'd13;
  localparam logic [GainW-1:0]  GainDerivRst = 12'd256;
  localparam logic [SpeedW-1:0] BaseSpeedRst = 16'd0;

  localparam logic [SensorW-1:0] PatternTable [TableLen] = '{
    5'd31, 5'd16, 5'd24, 5'd8, 5'd12, 5'd4, 5'd6, 5'd2, 5'd3, 5'd1, 5'd0
  };

  typedef struct packed {
    logic [SensorW-1:0] sensor_bits;
    logic               side_mark;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0]        position_index;
    logic                     pattern_known;
    logic [ModeW-1:0]         run_mode;
    logic signed [DriveW-1:0] steer_value;
    logic signed [DriveW-1:0] motor_left;
    logic signed [DriveW-1:0] motor_right;
    logic                     stop_mark;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] wr_data;
  } cfg_word_t;

  typedef struct packed {
    logic              known;
    logic [IndexW-1:0] index;
  } match_t;

  function automatic match_t pattern_lookup(input logic [SensorW-1:0] bits);
    match_t m;
    m.known = 1'b0;
    m.index = CenterIndex;
    for (int i = 0; i < TableLen; i++) begin
      if (bits == PatternTable[i]) begin
        m.known = 1'b1;
        m.index = IndexW'(i);
      end
    end
    return m;
  endfunction

endpackage

[rtl/core/lsps_channels.sv]
// Valid/ready channel interfaces for sample words, result words and config writes.
// Depends on lsps_pkg for the payload types.
`timescale 1ns / 1ps

interface lsps_in_if import lsps_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsps_out_if import lsps_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsps_cfg_if import lsps_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/line_sensor_pid_steering_core.sv]
// Line sensor PID steering core: pattern lookup, PID update and motor mix.
// A sample word goes into the input register, then into the result register once that can advance.
// Throughput: one sample word per cycle; the input register and the result
// register stall together only while a result word waits and the next sample word is held.
// Reset: rst_ni clears PID state, mark count and valids; gains and base speed take their defaults.
// Depends on lsps_pkg and the interfaces in lsps_channels.sv.
`timescale 1ns / 1ps

module line_sensor_pid_steering_core import lsps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsps_cfg_if.sink   cfg_i,
  lsps_in_if.sink    in_i,
  lsps_out_if.source out_o
);

  logic [GainW-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [SpeedW-1:0] base_speed_q;

  logic                     s1_valid_q;
  in_word_t                 s1_q;
  logic                     out_valid_q;
  out_word_t                out_q;

  logic signed [SumW-1:0]   error_sum_q, error_sum_d;
  logic signed [ErrW-1:0]   last_error_q, last_error_d;
  logic signed [DriveW-1:0] held_steer_q, held_steer_d;
  logic signed [DriveW-1:0] left_drive_q, left_drive_d;
  logic signed [DriveW-1:0] right_drive_q, right_drive_d;
  logic                     mark_count_q, mark_count_d;

  logic                      advance, load;
  match_t                    match;
  logic [IndexW-1:0]         pos_idx;
  logic [ModeW-1:0]          mode;
  logic                      pid_upd, stop;
  logic signed [ErrW-1:0]    err;
  logic signed [SumW:0]      sum_wide;
  logic signed [SumW-1:0]    sum_sat;
  logic signed [ErrW:0]      diff;
  logic signed [16:0]        p_prop;
  logic signed [28:0]        p_int;
  logic signed [17:0]        p_der;
  logic signed [30:0]        acc;
  logic signed [DriveW+1:0]  drv_l, drv_r;

  function automatic logic signed [DriveW-1:0] sat_acc(input logic signed [30:0] v);
    if (v > 31'sd8388607) return 24'sh7FFFFF;
    else if (v < -31'sd8388608) return 24'sh800000;
    else return DriveW'(v);
  endfunction

  function automatic logic signed [DriveW-1:0] sat_drv(input logic signed [DriveW+1:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    else if (v < -26'sd8388608) return 24'sh800000;
    else return DriveW'(v);
  endfunction

  assign advance     = !out_valid_q || out_o.ready;
  assign load        = s1_valid_q && advance;
  assign in_i.ready  = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    match   = pattern_lookup(s1_q.sensor_bits);
    pos_idx = match.index;
    if (match.known && pos_idx == DarkIndex) mode = ModeStopped;
    else if (match.known && pos_idx == LitIndex) mode = ModeCurve;
    else mode = ModeFollow;
    pid_upd = (pos_idx != CenterIndex) && (pos_idx != LitIndex) && (pos_idx != DarkIndex);

    stop         = s1_q.side_mark && mark_count_q;
    mark_count_d = s1_q.side_mark ? !mark_count_q : mark_count_q;

    err      = ErrW'($signed({1'b0, pos_idx}) - 5'sd5);
    sum_wide = (SumW+1)'(error_sum_q) + (SumW+1)'(err);
    if (sum_wide > 17'sd32767) sum_sat = 16'sh7FFF;
    else if (sum_wide < -17'sd32768) sum_sat = 16'sh8000;
    else sum_sat = SumW'(sum_wide);
    diff   = (ErrW+1)'(last_error_q) - (ErrW+1)'(err);
    p_prop = $signed({1'b0, gain_prop_q}) * err;
    p_int  = $signed({1'b0, gain_integ_q}) * sum_sat;
    p_der  = $signed({1'b0, gain_deriv_q}) * diff;
    acc    = 31'(p_prop) + 31'(p_int) + 31'(p_der);

    error_sum_d  = error_sum_q;
    last_error_d = last_error_q;
    held_steer_d = held_steer_q;
    if (pid_upd) begin
      error_sum_d  = sum_sat;
      last_error_d = err;
      held_steer_d = sat_acc(acc);
    end

    drv_l = (DriveW+2)'($signed({1'b0, base_speed_q})) + (DriveW+2)'(held_steer_d);
    drv_r = (DriveW+2)'($signed({1'b0, base_speed_q})) - (DriveW+2)'(held_steer_d);
    left_drive_d  = left_drive_q;
    right_drive_d = right_drive_q;
    if (mode != ModeStopped) begin
      left_drive_d  = sat_drv(drv_l);
      right_drive_d = sat_drv(drv_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= GainPropRst;
      gain_integ_q <= GainIntegRst;
      gain_deriv_q <= GainDerivRst;
      base_speed_q <= BaseSpeedRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        RegGainProp:  gain_prop_q  <= GainW'(cfg_i.data.wr_data);
        RegGainInteg: gain_integ_q <= GainW'(cfg_i.data.wr_data);
        RegGainDeriv: gain_deriv_q <= GainW'(cfg_i.data.wr_data);
        RegBaseSpeed: base_speed_q <= cfg_i.data.wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      error_sum_q   <= '0;
      last_error_q  <= '0;
      held_steer_q  <= '0;
      left_drive_q  <= '0;
      right_drive_q <= '0;
      mark_count_q  <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (advance) out_valid_q <= s1_valid_q;
      if (load) begin
        error_sum_q   <= error_sum_d;
        last_error_q  <= last_error_d;
        held_steer_q  <= held_steer_d;
        left_drive_q  <= left_drive_d;
        right_drive_q <= right_drive_d;
        mark_count_q  <= mark_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) s1_q <= in_i.data;
    if (load) begin
      out_q.position_index <= pos_idx;
      out_q.pattern_known  <= match.known;
      out_q.run_mode       <= mode;
      out_q.steer_value    <= held_steer_d;
      out_q.motor_left     <= left_drive_d;
      out_q.motor_right    <= right_drive_d;
      out_q.stop_mark      <= stop;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while result register empty");

  a_stop_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.stop_mark |-> !mark_count_q)
    else $error("mark count not cleared after stop mark");

  a_hold_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !pid_upd |=> held_steer_q == $past(held_steer_q))
    else $error("steering changed on a held sample");

  a_stopped_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && mode == ModeStopped |=> left_drive_q == $past(left_drive_q)
      && right_drive_q == $past(right_drive_q))
    else $error("motor drive changed while stopped");

endmodule
